// ----- rtl/b32d_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the bech32 string decoder.
// No dependencies; every other file imports this package.
package b32d_pkg;

    // string storage sizing
    localparam int MAX_LEN = 90;
    localparam int CNT_W   = $clog2(MAX_LEN + 1);
    localparam int IDX_W   = $clog2(MAX_LEN);

    // result status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_BAD_SEP  = 3'd1;
    localparam logic [2:0] ST_BAD_CHAR = 3'd2;
    localparam logic [2:0] ST_BAD_CSUM = 3'd3;
    localparam logic [2:0] ST_BAD_PAD  = 3'd4;
    localparam logic [2:0] ST_OVERLONG = 3'd5;

    // checksum generators
    localparam logic [29:0] GEN0 = 30'h3b6a57b2;
    localparam logic [29:0] GEN1 = 30'h26508e6d;
    localparam logic [29:0] GEN2 = 30'h1ea119fa;
    localparam logic [29:0] GEN3 = 30'h3d4233dd;
    localparam logic [29:0] GEN4 = 30'h2a1462b3;

    localparam logic [7:0] SEP_CHAR = 8'h31;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       end_of_string;
    } t_in_word;

    typedef struct packed {
        logic [7:0] data_byte;
        logic [2:0] status;
        logic       last_of_run;
    } t_out_word;

    // checksum unit control
    typedef struct packed {
        logic       init;
        logic       feed;
        logic [4:0] val;
    } t_poly_ctl;

    // regroup unit control
    typedef struct packed {
        logic       clear;
        logic       step;
        logic [4:0] sym;
    } t_rg_ctl;

    // A..Z to a..z, everything else unchanged
    function automatic logic [7:0] to_lower(input logic [7:0] c);
        logic [7:0] r;
        begin
            r = c;
            if (c >= 8'h41 && c <= 8'h5a) begin
                r = c + 8'd32;
            end
            return r;
        end
    endfunction

    // alphabet lookup: {valid, value}
    function automatic logic [5:0] sym_lookup(input logic [7:0] c);
        logic [5:0] r;
        begin
            case (c)
                "q": r = {1'b1, 5'd0};
                "p": r = {1'b1, 5'd1};
                "z": r = {1'b1, 5'd2};
                "r": r = {1'b1, 5'd3};
                "y": r = {1'b1, 5'd4};
                "9": r = {1'b1, 5'd5};
                "x": r = {1'b1, 5'd6};
                "8": r = {1'b1, 5'd7};
                "g": r = {1'b1, 5'd8};
                "f": r = {1'b1, 5'd9};
                "2": r = {1'b1, 5'd10};
                "t": r = {1'b1, 5'd11};
                "v": r = {1'b1, 5'd12};
                "d": r = {1'b1, 5'd13};
                "w": r = {1'b1, 5'd14};
                "0": r = {1'b1, 5'd15};
                "s": r = {1'b1, 5'd16};
                "3": r = {1'b1, 5'd17};
                "j": r = {1'b1, 5'd18};
                "n": r = {1'b1, 5'd19};
                "5": r = {1'b1, 5'd20};
                "4": r = {1'b1, 5'd21};
                "k": r = {1'b1, 5'd22};
                "h": r = {1'b1, 5'd23};
                "c": r = {1'b1, 5'd24};
                "e": r = {1'b1, 5'd25};
                "6": r = {1'b1, 5'd26};
                "m": r = {1'b1, 5'd27};
                "u": r = {1'b1, 5'd28};
                "a": r = {1'b1, 5'd29};
                "7": r = {1'b1, 5'd30};
                "l": r = {1'b1, 5'd31};
                default: r = 6'd0;
            endcase
            return r;
        end
    endfunction

    // one polymod step over a 5-bit value
    function automatic logic [29:0] poly_step(input logic [29:0] p, input logic [4:0] v);
        logic [29:0] r;
        logic [4:0]  top;
        begin
            top = p[29:25];
            r   = {p[24:0], v};
            if (top[0]) r = r ^ GEN0;
            if (top[1]) r = r ^ GEN1;
            if (top[2]) r = r ^ GEN2;
            if (top[3]) r = r ^ GEN3;
            if (top[4]) r = r ^ GEN4;
            return r;
        end
    endfunction

endpackage

// ----- rtl/b32d_char_mem.sv -----
`timescale 1ns / 1ps
// Character store: one write port, one registered read port.
// Depends on b32d_pkg.
module b32d_char_mem
    import b32d_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [IDX_W-1:0] i_wr_addr,
    input  logic [7:0]       i_wr_data,
    input  logic             i_rd_en,
    input  logic [IDX_W-1:0] i_rd_addr,
    output logic [7:0]       o_rd_data
);

    logic [7:0] r_mem [MAX_LEN];
    logic [7:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/b32d_polymod.sv -----
`timescale 1ns / 1ps
// Shared checksum unit: 30-bit polymod register, one 5-bit value per cycle.
// Depends on b32d_pkg.
module b32d_polymod
    import b32d_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_poly_ctl i_ctl,
    output logic      o_is_one
);

    logic [29:0] r_poly;
    logic [29:0] n_poly;

    // next checksum state
    always_comb begin
        n_poly = r_poly;
        if (i_ctl.init) begin
            n_poly = 30'd1;
        end else if (i_ctl.feed) begin
            n_poly = poly_step(r_poly, i_ctl.val);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poly <= 30'd1;
        end else begin
            r_poly <= n_poly;
        end
    end

    assign o_is_one = (r_poly == 30'd1);

endmodule

// ----- rtl/b32d_regroup.sv -----
`timescale 1ns / 1ps
// 5-bit to 8-bit regrouping unit with leftover padding check.
// Depends on b32d_pkg.
module b32d_regroup
    import b32d_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_rg_ctl    i_ctl,
    output logic       o_produce,
    output logic [7:0] o_byte,
    output logic       o_pad_bad
);

    logic [11:0] r_acc;
    logic [3:0]  r_bits;
    logic [11:0] acc_step;
    logic [3:0]  bits_step;
    logic [3:0]  shift;
    logic [7:0]  pad_mask;

    // one symbol shifted in
    always_comb begin
        acc_step  = {r_acc[6:0], i_ctl.sym};
        bits_step = r_bits + 4'd5;
        o_produce = (bits_step >= 4'd8);
        shift     = bits_step - 4'd8;
        o_byte    = acc_step[shift[2:0] +: 8];
    end

    // leftover bits must be fewer than five and all zero
    always_comb begin
        pad_mask  = (8'd1 << r_bits[2:0]) - 8'd1;
        o_pad_bad = (r_bits >= 4'd5) || ((r_acc[7:0] & pad_mask) != 8'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc  <= 12'd0;
            r_bits <= 4'd0;
        end else if (i_ctl.clear) begin
            r_acc  <= 12'd0;
            r_bits <= 4'd0;
        end else if (i_ctl.step) begin
            r_acc  <= acc_step;
            r_bits <= o_produce ? shift : bits_step;
        end
    end

endmodule

// ----- rtl/bech32_string_decoder_unit.sv -----
`timescale 1ns / 1ps
// Bech32 string decoder top level: sequencer, output register, unit wiring.
// Depends on b32d_pkg, b32d_char_mem, b32d_polymod, b32d_regroup.
//
// Input channel: one text byte per word (char_byte, end_of_string), taken
// with i_in_valid/o_in_ready. While a string is being collected the block
// takes one byte per cycle. After the final byte o_in_ready stays low while
// the string is checked and decoded.
// Output channel: one decoded payload byte per word, or a single error word
// (data_byte 0, nonzero status); last_of_run marks the final word of a string.
// Checking after the final byte reads the P prefix bytes twice (high bits, then
// low bits, with a zero value fed between) and the D data characters through
// the one-read-port character store into the shared checksum unit; then each
// of the K = D - 6 payload symbols is read again for regrouping and emission.
// Early errors (overlong, bad separator) are reported without reading the store.
// A stalled receiver holds the output register; emission waits on it, and a
// new string may be collected while the last word still waits.
// Reset (synchronous, active low) empties the output register and starts a
// new string; the character store is not cleared and needs no clearing.
module bech32_string_decoder_unit
    import b32d_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_word
);

    // sequencer states
    localparam logic [3:0] S_COLLECT = 4'd0;
    localparam logic [3:0] S_CHECK   = 4'd1;
    localparam logic [3:0] S_HI      = 4'd2;
    localparam logic [3:0] S_ZERO    = 4'd3;
    localparam logic [3:0] S_LO      = 4'd4;
    localparam logic [3:0] S_DATA    = 4'd5;
    localparam logic [3:0] S_DRAIN   = 4'd6;
    localparam logic [3:0] S_DECIDE  = 4'd7;
    localparam logic [3:0] S_ERD     = 4'd8;
    localparam logic [3:0] S_EPROC   = 4'd9;
    localparam logic [3:0] S_ERR     = 4'd10;

    // kind of the word coming out of the store
    localparam logic [1:0] K_HI   = 2'd0;
    localparam logic [1:0] K_ZERO = 2'd1;
    localparam logic [1:0] K_LO   = 2'd2;
    localparam logic [1:0] K_DATA = 2'd3;

    logic [3:0]       r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [IDX_W-1:0] r_sep, n_sep;
    logic             r_seen, n_seen;
    logic             r_over, n_over;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic             r_pend, n_pend;
    logic [1:0]       r_kind, n_kind;
    logic             r_pay, n_pay;
    logic             r_bad, n_bad;
    logic             r_any, n_any;
    logic [2:0]       r_err, n_err;
    logic             r_out_vld, n_out_vld;
    t_out_word        r_out_word, n_out_word;

    logic             in_acc;
    logic             out_free;
    logic [7:0]       lc;
    logic             wr_en;
    logic             rd_en;
    logic [7:0]       rd_data;
    logic [5:0]       sym;
    logic             sep_bad;
    logic             last_pay;
    logic             idx_sep_end;
    logic             idx_cnt_end;
    logic             pay_ok;
    t_poly_ctl        poly_ctl;
    logic             poly_one;
    t_rg_ctl          rg_ctl;
    logic             rg_produce;
    logic [7:0]       rg_byte;
    logic             rg_pad_bad;

    assign in_acc   = i_in_valid && o_in_ready;
    assign out_free = !r_out_vld || i_out_ready;
    assign lc       = to_lower(i_in_word.char_byte);
    assign wr_en    = in_acc && (r_count < CNT_W'(MAX_LEN));
    assign sym      = sym_lookup(rd_data);

    // index and length compares
    always_comb begin
        sep_bad     = !r_seen || (r_sep == '0) ||
                      ({1'b0, CNT_W'(r_sep)} + (CNT_W+1)'(7) > {1'b0, r_count});
        idx_sep_end = ({1'b0, r_idx} + (IDX_W+1)'(1) == {1'b0, r_sep});
        idx_cnt_end = ({1'b0, CNT_W'(r_idx)} + (CNT_W+1)'(1) == {1'b0, r_count});
        pay_ok      = ({1'b0, CNT_W'(r_idx)} + (CNT_W+1)'(6) < {1'b0, r_count});
        last_pay    = ({1'b0, CNT_W'(r_idx)} + (CNT_W+1)'(7) == {1'b0, r_count});
    end

    b32d_char_mem u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_count[IDX_W-1:0]),
        .i_wr_data (lc),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_idx),
        .o_rd_data (rd_data)
    );

    b32d_polymod u_poly (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (poly_ctl),
        .o_is_one (poly_one)
    );

    b32d_regroup u_rg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (rg_ctl),
        .o_produce (rg_produce),
        .o_byte    (rg_byte),
        .o_pad_bad (rg_pad_bad)
    );

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_sep      = r_sep;
        n_seen     = r_seen;
        n_over     = r_over;
        n_idx      = r_idx;
        n_pend     = 1'b0;
        n_kind     = r_kind;
        n_pay      = 1'b0;
        n_bad      = r_bad;
        n_any      = r_any;
        n_err      = r_err;
        n_out_vld  = r_out_vld && !i_out_ready;
        n_out_word = r_out_word;
        rd_en      = 1'b0;
        poly_ctl   = '0;
        rg_ctl     = '0;
        rg_ctl.sym = sym[4:0];

        // consume the word read last cycle
        if (r_pend) begin
            poly_ctl.feed = 1'b1;
            case (r_kind)
                K_HI:    poly_ctl.val = {2'b00, rd_data[7:5]};
                K_ZERO:  poly_ctl.val = 5'd0;
                K_LO:    poly_ctl.val = rd_data[4:0];
                K_DATA:  poly_ctl.val = sym[4:0];
                default: poly_ctl.val = 5'd0;
            endcase
            if (r_kind == K_DATA) begin
                if (!sym[5]) begin
                    n_bad = 1'b1;
                end
                if (r_pay) begin
                    rg_ctl.step = 1'b1;
                    if (rg_produce) begin
                        n_any = 1'b1;
                    end
                end
            end
        end

        case (r_state)
            S_COLLECT: begin
                if (in_acc) begin
                    if (wr_en) begin
                        if (lc == SEP_CHAR) begin
                            n_sep  = r_count[IDX_W-1:0];
                            n_seen = 1'b1;
                        end
                        n_count = r_count + CNT_W'(1);
                    end else begin
                        n_over = 1'b1;
                    end
                    if (i_in_word.end_of_string) begin
                        n_state = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                if (r_over) begin
                    n_err   = ST_OVERLONG;
                    n_state = S_ERR;
                end else if (sep_bad) begin
                    n_err   = ST_BAD_SEP;
                    n_state = S_ERR;
                end else begin
                    poly_ctl.init = 1'b1;
                    rg_ctl.clear  = 1'b1;
                    n_bad         = 1'b0;
                    n_any         = 1'b0;
                    n_idx         = '0;
                    n_state       = S_HI;
                end
            end
            S_HI: begin
                rd_en  = 1'b1;
                n_pend = 1'b1;
                n_kind = K_HI;
                if (idx_sep_end) begin
                    n_state = S_ZERO;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            S_ZERO: begin
                n_pend  = 1'b1;
                n_kind  = K_ZERO;
                n_idx   = '0;
                n_state = S_LO;
            end
            S_LO: begin
                rd_en  = 1'b1;
                n_pend = 1'b1;
                n_kind = K_LO;
                if (idx_sep_end) begin
                    n_idx   = r_sep + IDX_W'(1);
                    n_state = S_DATA;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            S_DATA: begin
                rd_en  = 1'b1;
                n_pend = 1'b1;
                n_kind = K_DATA;
                n_pay  = pay_ok;
                if (idx_cnt_end) begin
                    n_state = S_DRAIN;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            S_DRAIN: begin
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                if (r_bad) begin
                    n_err   = ST_BAD_CHAR;
                    n_state = S_ERR;
                end else if (!poly_one) begin
                    n_err   = ST_BAD_CSUM;
                    n_state = S_ERR;
                end else if (rg_pad_bad || !r_any) begin
                    n_err   = ST_BAD_PAD;
                    n_state = S_ERR;
                end else begin
                    rg_ctl.clear = 1'b1;
                    n_idx        = r_sep + IDX_W'(1);
                    n_state      = S_ERD;
                end
            end
            S_ERD: begin
                rd_en   = 1'b1;
                n_state = S_EPROC;
            end
            S_EPROC: begin
                if (out_free) begin
                    rg_ctl.step = 1'b1;
                    if (rg_produce) begin
                        n_out_vld              = 1'b1;
                        n_out_word.data_byte   = rg_byte;
                        n_out_word.status      = ST_OK;
                        n_out_word.last_of_run = last_pay;
                    end
                    if (last_pay) begin
                        n_count = '0;
                        n_sep   = '0;
                        n_seen  = 1'b0;
                        n_over  = 1'b0;
                        n_state = S_COLLECT;
                    end else begin
                        n_idx   = r_idx + IDX_W'(1);
                        n_state = S_ERD;
                    end
                end
            end
            S_ERR: begin
                if (out_free) begin
                    n_out_vld              = 1'b1;
                    n_out_word.data_byte   = 8'd0;
                    n_out_word.status      = r_err;
                    n_out_word.last_of_run = 1'b1;
                    n_count                = '0;
                    n_sep                  = '0;
                    n_seen                 = 1'b0;
                    n_over                 = 1'b0;
                    n_state                = S_COLLECT;
                end
            end
            default: begin
                n_state = S_COLLECT;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_COLLECT;
            r_count   <= '0;
            r_sep     <= '0;
            r_seen    <= 1'b0;
            r_over    <= 1'b0;
            r_idx     <= '0;
            r_pend    <= 1'b0;
            r_kind    <= K_HI;
            r_pay     <= 1'b0;
            r_bad     <= 1'b0;
            r_any     <= 1'b0;
            r_err     <= ST_OK;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_sep     <= n_sep;
            r_seen    <= n_seen;
            r_over    <= n_over;
            r_idx     <= n_idx;
            r_pend    <= n_pend;
            r_kind    <= n_kind;
            r_pay     <= n_pay;
            r_bad     <= n_bad;
            r_any     <= n_any;
            r_err     <= n_err;
            r_out_vld <= n_out_vld;
        end
    end

    // output payload register
    always_ff @(posedge i_clk) begin
        r_out_word <= n_out_word;
    end

    assign o_in_ready  = (r_state == S_COLLECT);
    assign o_out_valid = r_out_vld;
    assign o_out_word  = r_out_word;

endmodule

// ----- sim/bech32_string_decoder_unit_tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for bech32_string_decoder_unit: directed strings, then random
// well-formed and corrupted strings; each word is checked against the table or a predictor.
// Depends on b32d_pkg (word types, status codes, generators) and the decoder RTL.
module bech32_string_decoder_unit_tb;
    import b32d_pkg::*;

    localparam int ITEM_GOAL   = 370;
    localparam int CALM_TAIL   = 70;
    localparam int HOLD_CYCLES = 400;
    localparam int STALL_LIMIT = 3000;
    localparam int TAIL_CYCLES = 64;
    localparam int NUM_KINDS   = 10;
    localparam logic [0:31][7:0] SYMSET = "qpzry9x8gf2tvdw0s3jn54khce6mua7l";

    // shapes of generated strings
    typedef enum int {
        K_VALID, K_BIG, K_LONG, K_CSUM, K_BADCHAR,
        K_PAD, K_EMPTY, K_SHORT, K_NOSEP, K_NOISE
    } t_str_kind;

    typedef struct {
        string      txt;
        bit         seal;
        bit         typed;
        logic [2:0] want;
    } t_dir_row;

    logic      i_clk;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_ready;
    t_in_word  i_in_word   = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_word o_out_word;

    // expected decoder output and run bookkeeping
    t_out_word decoded_due[$];
    int        mismatches   = 0;
    int        chars_sent   = 0;
    int        strings_sent = 0;
    int        words_seen   = 0;
    int        quiet_cycles = 0;
    int        status_hits[8];
    bit        calm      = 1'b0;
    bit        hold_req  = 1'b0;
    bit        hold_done = 1'b0;

    // predictor copy of the per-string state
    logic [7:0] txt_buf [MAX_LEN];
    int         txt_len   = 0;
    int         sep_pos   = 0;
    bit         sep_found = 1'b0;
    bit         too_long  = 1'b0;

    // string under construction
    logic [7:0] text_q[$];
    int         sym_q[$];

    bech32_string_decoder_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        if (c >= "A" && c <= "Z") begin
            return c + 8'd32;
        end
        return c;
    endfunction

    // alphabet position, -1 when outside
    function automatic int sym_val(input logic [7:0] c);
        for (int i = 0; i < 32; i++) begin
            if (SYMSET[i] == c) begin
                return i;
            end
        end
        return -1;
    endfunction

    // one checksum step
    function automatic logic [29:0] crc_mix(input logic [29:0] acc, input logic [4:0] v);
        logic [29:0] nxt;
        logic [29:0] g;
        nxt = {acc[24:0], v};
        for (int i = 0; i < 5; i++) begin
            case (i)
                0: g = GEN0;
                1: g = GEN1;
                2: g = GEN2;
                3: g = GEN3;
                default: g = GEN4;
            endcase
            if (acc[25 + i]) begin
                nxt = nxt ^ g;
            end
        end
        return nxt;
    endfunction

    function automatic t_out_word err_word(input logic [2:0] code);
        t_out_word w;
        w.data_byte   = 8'h00;
        w.status      = code;
        w.last_of_run = 1'b1;
        return w;
    endfunction

    // decode the collected string into its output words
    function automatic void judge_string(ref t_out_word res[$]);
        logic [29:0] acc;
        int          grp;
        int          nbits;
        t_out_word   w;
        t_out_word   got[$];
        if (too_long) begin
            res = {res, err_word(ST_OVERLONG)};
            return;
        end
        if (!sep_found || sep_pos == 0 || sep_pos + 7 > txt_len) begin
            res = {res, err_word(ST_BAD_SEP)};
            return;
        end
        for (int i = sep_pos + 1; i < txt_len; i++) begin
            if (sym_val(txt_buf[i]) < 0) begin
                res = {res, err_word(ST_BAD_CHAR)};
                return;
            end
        end
        // prefix high bits, zero, prefix low bits, then data symbols
        acc = 30'd1;
        for (int i = 0; i < sep_pos; i++) begin
            acc = crc_mix(acc, 5'(txt_buf[i] >> 5));
        end
        acc = crc_mix(acc, 5'd0);
        for (int i = 0; i < sep_pos; i++) begin
            acc = crc_mix(acc, 5'(txt_buf[i]));
        end
        for (int i = sep_pos + 1; i < txt_len; i++) begin
            acc = crc_mix(acc, 5'(sym_val(txt_buf[i])));
        end
        if (acc != 30'd1) begin
            res = {res, err_word(ST_BAD_CSUM)};
            return;
        end
        // 5-bit to 8-bit regroup, checksum symbols excluded
        grp   = 0;
        nbits = 0;
        for (int i = sep_pos + 1; i < txt_len - 6; i++) begin
            grp   = ((grp << 5) | sym_val(txt_buf[i])) & 12'hfff;
            nbits = nbits + 5;
            if (nbits >= 8) begin
                nbits         = nbits - 8;
                w.data_byte   = 8'(grp >> nbits);
                w.status      = ST_OK;
                w.last_of_run = 1'b0;
                got           = {got, w};
            end
        end
        if (nbits >= 5 || ((grp << (8 - nbits)) & 8'hff) != 0 || got.size() == 0) begin
            res = {res, err_word(ST_BAD_PAD)};
            return;
        end
        got[got.size() - 1].last_of_run = 1'b1;
        foreach (got[i]) begin
            res = {res, got[i]};
        end
    endfunction

    // predictor: take one accepted text word
    function automatic void step_text(input t_in_word w, ref t_out_word res[$]);
        logic [7:0] c;
        c = fold_case(w.char_byte);
        if (txt_len < MAX_LEN) begin
            txt_buf[txt_len] = c;
            if (c == SEP_CHAR) begin
                sep_pos   = txt_len;
                sep_found = 1'b1;
            end
            txt_len++;
        end else begin
            too_long = 1'b1;
        end
        if (w.end_of_string) begin
            judge_string(res);
            txt_len   = 0;
            sep_pos   = 0;
            sep_found = 1'b0;
            too_long  = 1'b0;
        end
    endfunction

    // append six checksum characters to prefix, separator and data in text_q
    function automatic void seal_text();
        logic [29:0] acc;
        int          sp;
        sp = 0;
        foreach (text_q[i]) begin
            if (text_q[i] == SEP_CHAR) begin
                sp = i;
            end
        end
        acc = 30'd1;
        for (int i = 0; i < sp; i++) begin
            acc = crc_mix(acc, 5'(fold_case(text_q[i]) >> 5));
        end
        acc = crc_mix(acc, 5'd0);
        for (int i = 0; i < sp; i++) begin
            acc = crc_mix(acc, 5'(fold_case(text_q[i])));
        end
        for (int i = sp + 1; i < text_q.size(); i++) begin
            acc = crc_mix(acc, 5'(sym_val(fold_case(text_q[i]))));
        end
        for (int i = 0; i < 6; i++) begin
            acc = crc_mix(acc, 5'd0);
        end
        acc = acc ^ 30'd1;
        for (int i = 0; i < 6; i++) begin
            text_q = {text_q, SYMSET[5'(acc >> (5 * (5 - i)))]};
        end
    endfunction

    // random prefix of h bytes, separator, sym_q, checksum; letters in mixed case
    function automatic void build_coded(input int h);
        text_q.delete();
        for (int i = 0; i < h; i++) begin
            text_q = {text_q, 8'($urandom_range(0, 255))};
        end
        text_q = {text_q, SEP_CHAR};
        foreach (sym_q[i]) begin
            text_q = {text_q, SYMSET[sym_q[i]]};
        end
        seal_text();
        for (int i = h + 1; i < text_q.size(); i++) begin
            if (text_q[i] >= "a" && text_q[i] <= "z" && $urandom_range(0, 3) == 0) begin
                text_q[i] = text_q[i] - 8'd32;
            end
        end
    endfunction

    // n random payload bytes into 5-bit symbols, zero padded
    function automatic void pack_bytes(input int n);
        int acc;
        int nb;
        acc = 0;
        nb  = 0;
        sym_q.delete();
        for (int i = 0; i < n; i++) begin
            acc = ((acc << 8) | int'($urandom_range(0, 255))) & 12'hfff;
            nb  = nb + 8;
            while (nb >= 5) begin
                nb    = nb - 5;
                sym_q = {sym_q, (acc >> nb) & 31};
            end
        end
        if (nb > 0) begin
            sym_q = {sym_q, (acc << (5 - nb)) & 31};
        end
    endfunction

    function automatic void make_string(input t_str_kind kind);
        int         h;
        int         p;
        int         v;
        logic [7:0] b;
        h = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
        case (kind)
            K_VALID, K_CSUM, K_BADCHAR: begin
                pack_bytes($urandom_range(1, 8));
                build_coded(h);
                p = $urandom_range(h + 1, text_q.size() - 1);
                if (kind == K_CSUM) begin
                    // swap one data or checksum symbol for another
                    v = sym_val(fold_case(text_q[p]));
                    text_q[p] = SYMSET[5'(v + $urandom_range(1, 31))];
                end else if (kind == K_BADCHAR) begin
                    do begin
                        b = 8'($urandom_range(0, 255));
                    end while (sym_val(fold_case(b)) >= 0 || b == SEP_CHAR);
                    text_q[p] = b;
                end
            end
            K_BIG: begin
                // 51 payload bytes fill all 90 characters
                pack_bytes(51);
                build_coded(1);
            end
            K_PAD: begin
                sym_q.delete();
                repeat ($urandom_range(1, 12)) sym_q = {sym_q, int'($urandom_range(0, 31))};
                build_coded(h);
            end
            K_EMPTY: begin
                sym_q.delete();
                build_coded(h);
            end
            K_SHORT: begin
                text_q.delete();
                repeat (h) text_q = {text_q, 8'($urandom_range(0, 255))};
                text_q = {text_q, SEP_CHAR};
                repeat ($urandom_range(0, 5)) text_q = {text_q, SYMSET[$urandom_range(0, 31)]};
            end
            K_NOSEP: begin
                text_q.delete();
                repeat ($urandom_range(2, 12)) begin
                    do begin
                        b = 8'($urandom_range(0, 255));
                    end while (b == SEP_CHAR);
                    text_q = {text_q, b};
                end
            end
            K_NOISE: begin
                text_q.delete();
                repeat ($urandom_range(1, 12)) text_q = {text_q, 8'($urandom_range(0, 255))};
            end
            default: begin
                text_q.delete();
                repeat ($urandom_range(91, 96)) text_q = {text_q, 8'($urandom_range(0, 255))};
            end
        endcase
    endfunction

    function automatic t_str_kind pick_kind();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return K_VALID;
        if (r < 63) return K_CSUM;
        if (r < 70) return K_BADCHAR;
        if (r < 77) return K_PAD;
        if (r < 81) return K_EMPTY;
        if (r < 87) return K_SHORT;
        if (r < 91) return K_NOSEP;
        if (r < 97) return K_NOISE;
        if (r < 98) return K_LONG;
        return K_BIG;
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("[%0t] mismatch at word %0d:%s", $time, words_seen, what);
    endtask

    // offer one text word, wait for it to be taken, then predict
    task automatic send_char(input logic [7:0] b, input logic eos, input bit typed,
                             input logic [2:0] want);
        t_in_word  w;
        t_out_word res[$];
        if (!calm && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        w.char_byte     = b;
        w.end_of_string = eos;
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do @(posedge i_clk); while (!o_in_ready);
        chars_sent++;
        step_text(w, res);
        if (eos) begin
            strings_sent++;
            if (typed) begin
                decoded_due = {decoded_due, err_word(want)};
            end else begin
                foreach (res[i]) begin
                    decoded_due = {decoded_due, res[i]};
                end
            end
        end
    endtask

    task automatic send_text();
        foreach (text_q[i]) begin
            send_char(text_q[i], i == text_q.size() - 1, 1'b0, ST_OK);
        end
    endtask

    // stop offering and let every expected word come out
    task automatic drain_decoder();
        i_in_valid <= 1'b0;
        while (decoded_due.size() != 0) @(posedge i_clk);
    endtask

    // sender: reset, directed table, random strings, final drain
    initial begin
        t_dir_row  rows[5];
        t_str_kind kind;
        rows[0] = '{"1", 1'b0, 1'b1, ST_BAD_SEP};         // separator in first place
        rows[1] = '{"\377", 1'b0, 1'b1, ST_BAD_SEP};      // no separator at all
        rows[2] = '{"a1qqqqq", 1'b0, 1'b1, ST_BAD_SEP};   // only five data characters
        rows[3] = '{"A1qqqqqo", 1'b0, 1'b1, ST_BAD_CHAR}; // 'o' is not in the alphabet
        rows[4] = '{"\3771LU", 1'b1, 1'b0, ST_OK};        // 0xff prefix, payload byte 0xff
        foreach (status_hits[i]) begin
            status_hits[i] = 0;
        end
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < 5; r++) begin
            text_q.delete();
            for (int i = 0; i < rows[r].txt.len(); i++) begin
                text_q = {text_q, rows[r].txt[i]};
            end
            if (rows[r].seal) begin
                seal_text();
            end
            foreach (text_q[i]) begin
                send_char(text_q[i], i == text_q.size() - 1, rows[r].typed, rows[r].want);
            end
        end
        drain_decoder();

        // one string of each shape first, then a weighted mix
        for (int k = 0; chars_sent < ITEM_GOAL; k++) begin
            if (k < NUM_KINDS) begin
                kind = t_str_kind'(k);
            end else begin
                kind = pick_kind();
            end
            if (k == 3) begin
                hold_req = 1'b1;
            end
            if (k == NUM_KINDS) begin
                drain_decoder();
            end
            if (chars_sent >= ITEM_GOAL - CALM_TAIL) begin
                calm = 1'b1;
            end
            make_string(kind);
            send_text();
        end

        drain_decoder();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("run: %0d strings of %0d text bytes, %0d output words,",
                 strings_sent, chars_sent, words_seen);
        $display("  one %0d-cycle output stall; status mix: ok %0d, sep %0d, char %0d, %s",
                 HOLD_CYCLES, status_hits[ST_OK], status_hits[ST_BAD_SEP],
                 status_hits[ST_BAD_CHAR],
                 $sformatf("csum %0d, pad %0d, overlong %0d", status_hits[ST_BAD_CSUM],
                           status_hits[ST_BAD_PAD], status_hits[ST_OVERLONG]));
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // receiver: random ready bursts, one long hold-off, steady at the end
    initial begin
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (hold_req && !hold_done) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_done = 1'b1;
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
    end

    // compare each output word with the oldest expectation
    always @(posedge i_clk) begin : word_check
        t_out_word want;
        string     msg;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            words_seen++;
            status_hits[o_out_word.status]++;
            if (decoded_due.size() == 0) begin
                report_mismatch($sformatf(" unexpected word %h", o_out_word));
            end else begin
                want = decoded_due.pop_front();
                msg  = "";
                if (o_out_word.data_byte !== want.data_byte) begin
                    msg = {msg, $sformatf(" data_byte %h want %h",
                                          o_out_word.data_byte, want.data_byte)};
                end
                if (o_out_word.status !== want.status) begin
                    msg = {msg, $sformatf(" status %0d want %0d",
                                          o_out_word.status, want.status)};
                end
                if (o_out_word.last_of_run !== want.last_of_run) begin
                    msg = {msg, $sformatf(" last_of_run %b want %b",
                                          o_out_word.last_of_run, want.last_of_run)};
                end
                if (msg != "") begin
                    report_mismatch(msg);
                end
            end
        end
    end

    // watchdog on cycles with no word moving on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("no progress for %0d cycles, %0d words outstanding",
                     quiet_cycles, decoded_due.size());
            $display("TB_ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule
